// ===== hdl/sce_pkg.sv =====
package sce_pkg;

	localparam int unsigned CHUNK_W  = 6;
	localparam int unsigned VAL_W    = 5 * CHUNK_W;
	localparam int unsigned COORD_W  = 32;
	localparam int unsigned OP_W     = 3;
	localparam int unsigned S_DATA_W = 168;
	localparam int unsigned M_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_MOVE_X    = 3'd0,
		OP_MOVE_Y    = 3'd1,
		OP_PEN       = 3'd2,
		OP_SET_PAUSE = 3'd3,
		OP_REP_PAUSE = 3'd4,
		OP_DRAW      = 3'd5
	} op_t;

	// steps of a draw-line command
	typedef enum logic [6:0] {
		STEP_PEN_LIFT = 7'b000_0001,
		STEP_MX_START = 7'b000_0010,
		STEP_MY_START = 7'b000_0100,
		STEP_PEN_DOWN = 7'b000_1000,
		STEP_MX_END   = 7'b001_0000,
		STEP_MY_END   = 7'b010_0000,
		STEP_PEN_UP   = 7'b100_0000
	} step_t;

	typedef enum logic [1:0] {
		SEG_MOVE  = 2'd0,
		SEG_PAUSE = 2'd1,
		SEG_PEN   = 2'd2
	} seg_kind_t;

	localparam logic [7:0] PREFIX_BASE = 8'h80;
	localparam logic [7:0] PEN_CODE    = 8'hC0;
	localparam logic [7:0] PAUSE_CODE  = 8'hC1;

	// input item, opcode in the lowest bits
	typedef struct packed {
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] amount;
		op_t                       opcode;
	} item_t;

	localparam int unsigned ITEM_W = $bits(item_t);

	// one segment of byte output, handed from front to back
	typedef struct packed {
		seg_kind_t        kind;
		logic [VAL_W-1:0] val;
		logic             ytag;
		logic             last;
	} seg_t;

endpackage

// ===== hdl/sce_front.sv =====
module sce_front
	import sce_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  push,
	output seg_t  seg,
	input  logic  q_ready
);

	logic                held_q;
	step_t               step_q;
	item_t               item_q;
	logic [COORD_W-1:0]  cur_x_q;
	logic [COORD_W-1:0]  cur_y_q;
	logic                pen_q;
	logic                seg_en;
	logic                seg_last;
	logic                advance;
	logic                accept;
	logic                first_x;
	logic                first_y;
	logic [COORD_W-1:0]  diff_x;
	logic [COORD_W-1:0]  diff_y;

	assign first_x = (step_q == STEP_MX_START);
	assign first_y = (step_q == STEP_MY_START);
	assign diff_x  = (first_x ? item_q.start_x : item_q.end_x)
	               - (first_x ? cur_x_q : item_q.start_x);
	assign diff_y  = (first_y ? item_q.start_y : item_q.end_y)
	               - (first_y ? cur_y_q : item_q.start_y);

	always_comb begin
		seg      = '0;
		seg_en   = 1'b0;
		seg_last = 1'b1;
		case (item_q.opcode)
			OP_MOVE_X, OP_MOVE_Y: begin
				seg.kind = SEG_MOVE;
				seg.val  = item_q.amount[VAL_W-1:0];
				seg.ytag = (item_q.opcode == OP_MOVE_Y);
				seg_en   = 1'b1;
			end
			OP_PEN: begin
				seg.kind = SEG_PEN;
				seg_en   = 1'b1;
			end
			OP_SET_PAUSE: begin
				seg.kind = SEG_PAUSE;
				seg.val  = item_q.amount[VAL_W-1:0];
				seg_en   = 1'b1;
			end
			OP_REP_PAUSE: begin
				// same bytes as a pause of zero
				seg.kind = SEG_PAUSE;
				seg_en   = 1'b1;
			end
			OP_DRAW: begin
				seg_last = (step_q == STEP_PEN_UP);
				case (step_q)
					STEP_PEN_LIFT: begin
						seg.kind = SEG_PEN;
						seg_en   = pen_q;
					end
					STEP_MX_START, STEP_MX_END: begin
						seg.kind = SEG_MOVE;
						seg.val  = diff_x[VAL_W-1:0];
						seg_en   = 1'b1;
					end
					STEP_MY_START, STEP_MY_END: begin
						seg.kind = SEG_MOVE;
						seg.val  = diff_y[VAL_W-1:0];
						seg.ytag = 1'b1;
						seg_en   = 1'b1;
					end
					STEP_PEN_DOWN, STEP_PEN_UP: begin
						seg.kind = SEG_PEN;
						seg_en   = 1'b1;
					end
					default: begin
						seg_en = 1'b0;
					end
				endcase
			end
			default: begin
				// unused opcode: drop without output
				seg_en = 1'b0;
			end
		endcase
		seg.last = seg_last;
	end

	assign advance  = held_q && (!seg_en || q_ready);
	assign push     = held_q && seg_en && q_ready;
	assign in_ready = !held_q || (advance && seg_last);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			step_q <= STEP_PEN_LIFT;
		end else begin
			if (accept) begin
				held_q <= 1'b1;
				step_q <= STEP_PEN_LIFT;
			end else if (advance) begin
				if (seg_last) begin
					held_q <= 1'b0;
				end else begin
					step_q <= step_t'({step_q[5:0], 1'b0});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			pen_q   <= 1'b0;
		end else if (push) begin
			if (seg.kind == SEG_PEN) begin
				pen_q <= !pen_q;
			end
			case (item_q.opcode)
				OP_MOVE_X: cur_x_q <= cur_x_q + item_q.amount;
				OP_MOVE_Y: cur_y_q <= cur_y_q + item_q.amount;
				OP_DRAW: begin
					case (step_q)
						STEP_MX_START: cur_x_q <= item_q.start_x;
						STEP_MY_START: cur_y_q <= item_q.start_y;
						STEP_MX_END:   cur_x_q <= item_q.end_x;
						STEP_MY_END:   cur_y_q <= item_q.end_y;
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// a draw line always leaves the pen up
	ast_draw_pen_up: assert property (@(posedge clk) disable iff (!arst_n)
		advance && seg_last && item_q.opcode == OP_DRAW |=> !pen_q)
		else $error("pen left down after draw line");

	ast_step_only_draw: assert property (@(posedge clk) disable iff (!arst_n)
		held_q && item_q.opcode != OP_DRAW |-> step_q == STEP_PEN_LIFT)
		else $error("step advanced on a single-segment command");

endmodule

// ===== hdl/sce_queue.sv =====
module sce_queue
	import sce_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  seg_t wr_seg,
	output logic wr_ready,
	input  logic pop,
	output seg_t rd_seg,
	output logic rd_valid
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	seg_t             mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_seg   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	ast_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CNT_W'(DEPTH))
		else $error("push into full queue");

	ast_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

// ===== hdl/sce_back.sv =====
module sce_back
	import sce_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  seg_t                q_seg,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [M_DATA_W-1:0] out_byte,
	output logic                out_last
);

	seg_t                busy_seg_q;
	logic                busy_q;
	logic [2:0]          idx_q;
	logic                fin_q;
	logic                load;
	logic [2:0]          k_start;
	logic [CHUNK_W-1:0]  chunk;
	logic [M_DATA_W-1:0] next_byte;
	logic [2:0]          idx_lo;
	logic [CHUNK_W-1:0]  c4, c3, c2, c1, c0;
	logic                valid_q;
	logic [M_DATA_W-1:0] byte_q;
	logic                last_q;

	assign c4 = q_seg.val[5*CHUNK_W-1:4*CHUNK_W];
	assign c3 = q_seg.val[4*CHUNK_W-1:3*CHUNK_W];
	assign c2 = q_seg.val[3*CHUNK_W-1:2*CHUNK_W];
	assign c1 = q_seg.val[2*CHUNK_W-1:CHUNK_W];
	assign c0 = q_seg.val[CHUNK_W-1:0];

	// first prefix chunk: one above the highest non-zero chunk, capped at four
	always_comb begin
		if (c4 != '0 || c3 != '0) begin
			k_start = 3'd4;
		end else if (c2 != '0) begin
			k_start = 3'd3;
		end else if (c1 != '0) begin
			k_start = 3'd2;
		end else if (c0 != '0 || q_seg.kind == SEG_MOVE) begin
			k_start = 3'd1;
		end else begin
			k_start = 3'd0;
		end
	end

	always_comb begin
		case (idx_q)
			3'd0:    chunk = busy_seg_q.val[CHUNK_W-1:0];
			3'd1:    chunk = busy_seg_q.val[2*CHUNK_W-1:CHUNK_W];
			3'd2:    chunk = busy_seg_q.val[3*CHUNK_W-1:2*CHUNK_W];
			3'd3:    chunk = busy_seg_q.val[4*CHUNK_W-1:3*CHUNK_W];
			3'd4:    chunk = busy_seg_q.val[5*CHUNK_W-1:4*CHUNK_W];
			default: chunk = '0;
		endcase
	end

	always_comb begin
		if (!fin_q) begin
			next_byte = PREFIX_BASE | {2'b00, chunk};
		end else begin
			case (busy_seg_q.kind)
				SEG_PEN:   next_byte = PEN_CODE;
				SEG_PAUSE: next_byte = PAUSE_CODE;
				default:   next_byte = {1'b0, busy_seg_q.ytag, busy_seg_q.val[CHUNK_W-1:0]};
			endcase
		end
	end

	// pause prefixes run down to chunk zero, move prefixes stop at chunk one
	assign idx_lo = (busy_seg_q.kind == SEG_PAUSE) ? 3'd0 : 3'd1;

	assign load = busy_q && (!valid_q || out_ready);
	assign pop  = q_valid && (!busy_q || (load && fin_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			fin_q  <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= k_start;
				fin_q  <= (q_seg.kind == SEG_PEN);
			end else if (load) begin
				if (fin_q) begin
					busy_q <= 1'b0;
				end else if (idx_q == idx_lo) begin
					fin_q <= 1'b1;
				end else begin
					idx_q <= idx_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			busy_seg_q <= q_seg;
		end
		if (load) begin
			byte_q <= next_byte;
			last_q <= busy_seg_q.last && fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	ast_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !fin_q |-> idx_q <= 3'd4 && idx_q >= idx_lo)
		else $error("chunk index out of range");

endmodule

// ===== hdl/sketch_command_byte_encoder_core.sv =====
// Sketch command byte encoder.
// Input stream (s_*): one drawing command per transfer. Output stream (m_*):
// the encoded command bytes, one per transfer, with m_tlast on the final byte
// that a command produces. Unused opcodes produce no bytes.
// A front stage decodes each command into byte segments (one move, pause or
// pen code each) and keeps the cursor and pen flag; a segment queue of
// QUEUE_DEPTH entries feeds a back stage that expands segments into bytes.
// Throughput: one output byte per cycle while m_tready is high; a command
// produces 1 to 23 bytes (a draw line up to 23, a move up to 5, a set pause
// up to 6). The front decodes one segment per cycle while the queue has room.
// From an input transfer to the first byte on m_tvalid a command passes the
// front item register, a queue entry, the back segment register and the output
// register; a draw line with the pen up first passes its empty pen-lift step.
// Reset clears the cursor to zero, lifts the pen and empties the queue and
// output register. When m_tready is low the output register holds its byte,
// the back stage stalls, the queue fills and then s_tready drops.
module sketch_command_byte_encoder_core
	import sce_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// opcode[2:0], amount[34:3], start_x[66:35], start_y[98:67],
	// end_x[130:99], end_y[162:131], zero pad[167:163]
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// code_byte[7:0]
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	item_t in_item;
	seg_t  front_seg;
	seg_t  back_seg;
	logic  push;
	logic  q_ready;
	logic  pop;
	logic  q_valid;

	assign in_item = item_t'(s_tdata[ITEM_W-1:0]);

	sce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.push     (push),
		.seg      (front_seg),
		.q_ready  (q_ready)
	);

	sce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_seg   (front_seg),
		.wr_ready (q_ready),
		.pop      (pop),
		.rd_seg   (back_seg),
		.rd_valid (q_valid)
	);

	sce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_seg     (back_seg),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
